[sv/psgpt_pkg.sv]
// ----------------------------------------------------------------------------
// psgpt_pkg
// Shared types and constants for the sound generator register write pitch
// tracker.
// ----------------------------------------------------------------------------
package psgpt_pkg;

    localparam int VOICE_COUNT = 4;
    localparam int NUMER_W     = 17;
    localparam int REG_W       = 10;
    localparam int ADDR_W      = 3;
    localparam int RF_DEPTH    = 1 << ADDR_W;
    localparam int VOICE_W     = ADDR_W - 1;
    localparam int NIB_W       = 4;
    localparam int HI_W        = REG_W - NIB_W;
    localparam int BYTE_W      = 8;
    localparam int DIV_STEPS   = NUMER_W;
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);
    localparam int OUT_W       = VOICE_W + NUMER_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam int LATCH_BIT   = 7;

    localparam logic [NUMER_W-1:0] NUMER_RESET = NUMER_W'(111563);
    localparam logic [REG_W-1:0]   TONE_RESET  = '0;
    localparam logic [REG_W-1:0]   ATTN_RESET  = REG_W'(15);
    localparam logic [VOICE_W-1:0] VOICE_FLIP  = '1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [REG_W-1:0]  data;
    } t_rf_wr;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TONE,
        S_RD_ATTN,
        S_WRITE,
        S_CHECK,
        S_DIV_OLD,
        S_WAIT_OLD,
        S_DIV_NEW,
        S_WAIT_NEW,
        S_CMP,
        S_EMIT
    } t_state;

endpackage

[sv/psgpt_regfile.sv]
// ----------------------------------------------------------------------------
// psgpt_regfile
// Tone and attenuation register file, one write port, one read port.
// ----------------------------------------------------------------------------
module psgpt_regfile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psgpt_pkg::t_rf_wr               i_wr,
    input  logic [psgpt_pkg::ADDR_W-1:0]    i_raddr,
    output logic [psgpt_pkg::REG_W-1:0]     o_rdata
);
    import psgpt_pkg::*;

    logic [REG_W-1:0] r_regs [RF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RF_DEPTH; i++) begin
                r_regs[i] <= (i % 2 == 1) ? ATTN_RESET : TONE_RESET;
            end
        end else if (i_wr.we) begin
            r_regs[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rdata = r_regs[i_raddr];

endmodule

[sv/psgpt_divider.sv]
// ----------------------------------------------------------------------------
// psgpt_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psgpt_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [psgpt_pkg::NUMER_W-1:0]   i_dividend,
    input  logic [psgpt_pkg::REG_W-1:0]     i_divisor,
    output psgpt_pkg::t_div_stat            o_stat,
    output logic [psgpt_pkg::NUMER_W-1:0]   o_quotient
);
    import psgpt_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUMER_W-1:0] r_quo;
    logic [REG_W-1:0]   r_rem;
    logic [REG_W-1:0]   r_div;
    logic [REG_W:0]     rem_shift;
    logic               fits;

    assign rem_shift = {r_rem, r_quo[NUMER_W-1]};
    assign fits      = rem_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= REG_W'(rem_shift - {1'b0, r_div});
            end else begin
                r_rem <= rem_shift[REG_W-1:0];
            end
            r_quo <= {r_quo[NUMER_W-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[sv/psg_register_write_pitch_tracker_top.sv]
// ----------------------------------------------------------------------------
// psg_register_write_pitch_tracker_top
// Tracks tone/attenuation register writes and reports pitch changes.
// ----------------------------------------------------------------------------
// Flow: one item at a time, taken only in idle. An item whose pitch cannot change
//   skips the divider; otherwise the old and new frequencies are each divided when
//   live, each division 17 steps on the single shared restoring divider.
// Reset: synchronous active low; registers return to even 0 / odd 15,
//   latch to 0, numerator to 111563, output empty.
module psg_register_write_pitch_tracker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [psgpt_pkg::BYTE_W-1:0]       i_s_axis_tdata,  // [7:0] data_byte
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [psgpt_pkg::OUT_BYTES_W-1:0]  o_m_axis_tdata,  // [1:0] voice_channel,
                                                                // [18:2] new_frequency
    input  logic                               i_cfg_we,
    input  logic [psgpt_pkg::NUMER_W-1:0]      i_cfg_wdata
);
    import psgpt_pkg::*;

    t_state             r_state, n_state;
    logic [NUMER_W-1:0] r_numer;
    logic [ADDR_W-1:0]  r_lat;
    logic [BYTE_W-1:0]  r_byte;
    logic [REG_W-1:0]   r_tone_old, r_attn_old, r_tone_new, r_attn_new;
    logic [NUMER_W-1:0] r_freq_old, r_freq_new;
    logic               r_o_valid;
    logic [OUT_W-1:0]   r_o_data;

    t_rf_wr             rf_wr;
    logic [ADDR_W-1:0]  rf_raddr;
    logic [REG_W-1:0]   rf_rdata;
    logic               div_start;
    logic [REG_W-1:0]   div_divisor;
    t_div_stat          div_stat;
    logic [NUMER_W-1:0] div_quo;

    logic [REG_W-1:0]   old_val, new_val;
    logic               voice_ok, live_old, live_new, out_free;

    assign voice_ok = {1'b0, r_lat[ADDR_W-1:1]} < ADDR_W'(VOICE_COUNT);
    assign old_val  = r_lat[0] ? r_attn_old : r_tone_old;
    assign new_val  = r_byte[LATCH_BIT] ? {old_val[REG_W-1:NIB_W], r_byte[NIB_W-1:0]}
                                        : {r_byte[HI_W-1:0], old_val[NIB_W-1:0]};
    assign live_old = voice_ok && (r_attn_old == '0) && (r_tone_old != '0);
    assign live_new = voice_ok && (r_attn_new == '0) && (r_tone_new != '0);
    assign out_free = !r_o_valid || i_m_axis_tready;

    psgpt_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rf_wr),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    psgpt_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_numer),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_s_axis_tvalid) n_state = S_RD_TONE;
            S_RD_TONE:  n_state = S_RD_ATTN;
            S_RD_ATTN:  n_state = S_WRITE;
            S_WRITE:    n_state = S_CHECK;
            S_CHECK: begin
                if (live_old == live_new && (!live_old || r_tone_old == r_tone_new)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DIV_OLD;
                end
            end
            S_DIV_OLD:  n_state = live_old ? S_WAIT_OLD : S_DIV_NEW;
            S_WAIT_OLD: if (div_stat.done) n_state = S_DIV_NEW;
            S_DIV_NEW:  n_state = live_new ? S_WAIT_NEW : S_CMP;
            S_WAIT_NEW: if (div_stat.done) n_state = S_CMP;
            S_CMP:      n_state = (r_freq_old != r_freq_new) ? S_EMIT : S_IDLE;
            S_EMIT:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        rf_raddr    = {r_lat[ADDR_W-1:1], 1'b0};
        rf_wr.we    = 1'b0;
        rf_wr.addr  = r_lat;
        rf_wr.data  = new_val;
        div_start   = 1'b0;
        div_divisor = r_tone_old;
        unique case (r_state)
            S_RD_ATTN: rf_raddr  = {r_lat[ADDR_W-1:1], 1'b1};
            S_WRITE:   rf_wr.we  = voice_ok;
            S_DIV_OLD: div_start = live_old;
            S_DIV_NEW: begin
                div_start   = live_new;
                div_divisor = r_tone_new;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_numer   <= NUMER_RESET;
            r_lat     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_numer <= i_cfg_wdata;
            end
            if (r_state == S_IDLE && i_s_axis_tvalid && i_s_axis_tdata[LATCH_BIT]) begin
                r_lat <= i_s_axis_tdata[BYTE_W-2 -: ADDR_W];
            end
            if (r_state == S_EMIT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE:    if (i_s_axis_tvalid) r_byte <= i_s_axis_tdata;
            S_RD_TONE: r_tone_old <= rf_rdata;
            S_RD_ATTN: r_attn_old <= rf_rdata;
            S_WRITE: begin
                r_tone_new <= (voice_ok && !r_lat[0]) ? new_val : r_tone_old;
                r_attn_new <= (voice_ok &&  r_lat[0]) ? new_val : r_attn_old;
            end
            S_DIV_OLD:  if (!live_old) r_freq_old <= '0;
            S_WAIT_OLD: if (div_stat.done) r_freq_old <= div_quo;
            S_DIV_NEW:  if (!live_new) r_freq_new <= '0;
            S_WAIT_NEW: if (div_stat.done) r_freq_new <= div_quo;
            S_EMIT: begin
                if (out_free) r_o_data <= {r_freq_new, r_lat[ADDR_W-1:1] ^ VOICE_FLIP};
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = OUT_BYTES_W'(r_o_data);

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for psg_register_write_pitch_tracker_top. Bytes written
// to the sound port go in over the input stream and are fed to an in-bench
// pitch predictor. Pitch-change items on the output stream are matched in
// order against the predicted queue. A short directed table runs at the reset
// numerator. Random phases follow, each with its own numerator and its own
// sender burst and receiver stall pattern.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psgpt_pkg::*;

    localparam int IDLE_WAIT   = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 220;
    localparam int PHASES      = 7;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [NUMER_W-1:0] freq;
    } t_pitch_change;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_CHANGE,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        t_row_kind          kind;
        logic [VOICE_W-1:0] voice;
        logic [NUMER_W-1:0] freq;
    } t_stim_row;

    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_HOLD
    } t_rdy_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [BYTE_W-1:0]      i_s_axis_tdata;   // [7:0] data_byte
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] o_m_axis_tdata;   // [1:0] voice_channel, [18:2] new_frequency
    logic                   i_cfg_we;
    logic [NUMER_W-1:0]     i_cfg_wdata;

    psg_register_write_pitch_tracker_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // directed rows at the reset numerator
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{8'h80, ROW_NO_CHANGE, 2'd0, 17'd0},
        '{8'h90, ROW_NO_CHANGE, 2'd0, 17'd0},
        '{8'h81, ROW_TYPED,     2'd3, 17'd111563},
        '{8'h3F, ROW_PREDICT,   2'd0, 17'd0},
        '{8'h7F, ROW_NO_CHANGE, 2'd0, 17'd0},
        '{8'h00, ROW_PREDICT,   2'd0, 17'd0},
        '{8'h8F, ROW_PREDICT,   2'd0, 17'd0},
        '{8'h80, ROW_TYPED,     2'd3, 17'd0},
        '{8'h81, ROW_TYPED,     2'd3, 17'd111563},
        '{8'h91, ROW_TYPED,     2'd3, 17'd0},
        '{8'h90, ROW_TYPED,     2'd3, 17'd111563},
        '{8'h01, ROW_TYPED,     2'd3, 17'd0},
        '{8'h40, ROW_TYPED,     2'd3, 17'd111563},
        '{8'hF0, ROW_NO_CHANGE, 2'd0, 17'd0},
        '{8'hE0, ROW_NO_CHANGE, 2'd0, 17'd0},
        '{8'hEF, ROW_PREDICT,   2'd0, 17'd0},
        '{8'h3F, ROW_PREDICT,   2'd0, 17'd0},
        '{8'hFF, ROW_TYPED,     2'd0, 17'd0},
        '{8'hB0, ROW_NO_CHANGE, 2'd0, 17'd0},
        '{8'hA5, ROW_PREDICT,   2'd0, 17'd0},
        '{8'hD0, ROW_NO_CHANGE, 2'd0, 17'd0},
        '{8'hC2, ROW_PREDICT,   2'd0, 17'd0},
        '{8'h40, ROW_NO_CHANGE, 2'd0, 17'd0},
        '{8'hC1, ROW_PREDICT,   2'd0, 17'd0}
    };

    // predictor state
    logic [REG_W-1:0]   tone_attn_q [RF_DEPTH];
    logic [ADDR_W-1:0]  latched_reg_q;
    logic [NUMER_W-1:0] numerator_q;

    t_pitch_change pitch_change_q [$];

    int        err_count;
    int        items_sent;
    int        burst_left;
    int        gap_max;
    int        burst_max;
    t_rdy_mode rdy_mode;
    int        rdy_hold;
    int        idle_cycles;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic logic [NUMER_W-1:0] voice_freq(input logic [ADDR_W-1:0] reg_idx);
        logic [ADDR_W-1:0] pair;
        logic [REG_W-1:0]  tone;
        logic [REG_W-1:0]  attn;
        pair = reg_idx & 3'b110;
        if (int'(pair >> 1) >= VOICE_COUNT) return '0;
        tone = tone_attn_q[pair];
        attn = tone_attn_q[pair | 3'b001];
        if (attn != '0 || tone == '0) return '0;
        return NUMER_W'(numerator_q / tone);
    endfunction

    task automatic reset_pitch_model();
        for (int i = 0; i < RF_DEPTH; i++) begin
            tone_attn_q[i] = (i % 2) ? ATTN_RESET : TONE_RESET;
        end
        latched_reg_q = '0;
        numerator_q   = NUMER_RESET;
    endtask

    task automatic apply_port_write(input logic [BYTE_W-1:0] b, output logic changed,
                                    output t_pitch_change pc);
        logic [ADDR_W-1:0]  r;
        logic [NUMER_W-1:0] old_freq;
        logic [NUMER_W-1:0] new_freq;
        if (b[LATCH_BIT]) latched_reg_q = b[6:4];
        r = latched_reg_q;
        old_freq = voice_freq(r);
        if (int'(r >> 1) < VOICE_COUNT) begin
            if (b[LATCH_BIT]) tone_attn_q[r][NIB_W-1:0] = b[NIB_W-1:0];
            else tone_attn_q[r][REG_W-1:NIB_W] = b[HI_W-1:0];
        end
        new_freq = voice_freq(r);
        changed  = (old_freq != new_freq);
        pc.voice = r[ADDR_W-1:1] ^ VOICE_FLIP;
        pc.freq  = new_freq;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input t_row_kind kind,
                             input t_pitch_change typed);
        int            gap;
        logic          changed;
        t_pitch_change pc;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
        items_sent++;
        apply_port_write(b, changed, pc);
        case (kind)
            ROW_PREDICT: if (changed) pitch_change_q.push_back(pc);
            ROW_TYPED: pitch_change_q.push_back(typed);
            default: ;
        endcase
    endtask

    task automatic send_random(input logic [BYTE_W-1:0] b);
        send_byte(b, ROW_PREDICT, '0);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain();
        while (pitch_change_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_numerator(input logic [NUMER_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        numerator_q = v;
    endtask

    // random write sequences; most build a silent-to-tone path on one voice
    task automatic random_sequence();
        int                 sel;
        logic [VOICE_W-1:0] v;
        v   = VOICE_W'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel <= 2) begin
            send_random(BYTE_W'($urandom_range(0, 255)));
        end else if (sel <= 4) begin
            send_random({1'b1, v, 1'b1, 4'h0});
            send_random({1'b0, 1'($urandom_range(0, 1)), 6'h00});
        end else if (sel <= 8) begin
            send_random({1'b1, v, 1'b0, 4'($urandom)});
            if ($urandom_range(0, 2) != 0) send_random({1'b0, 7'($urandom)});
        end else begin
            send_random({1'b1, v, 1'b1, 4'($urandom)});
        end
    endtask

    // output side: compare and stall pattern
    always @(posedge i_clk) begin
        t_pitch_change want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pitch_change_q.size() == 0) begin
                report("unexpected item voice", 32'(o_m_axis_tdata[VOICE_W-1:0]), 0);
            end else begin
                want = pitch_change_q.pop_front();
                if (o_m_axis_tdata[VOICE_W-1:0] != want.voice)
                    report("voice_channel", 32'(o_m_axis_tdata[VOICE_W-1:0]), 32'(want.voice));
                if (o_m_axis_tdata[OUT_W-1:VOICE_W] != want.freq)
                    report("new_frequency", 32'(o_m_axis_tdata[OUT_W-1:VOICE_W]),
                           32'(want.freq));
            end
        end
        case (rdy_mode)
            RDY_ALWAYS: i_m_axis_tready <= 1'b1;
            RDY_RANDOM: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rdy_hold == 0) begin
                    i_m_axis_tready <= ~i_m_axis_tready;
                    rdy_hold = $urandom_range(1, 40);
                end else begin
                    rdy_hold--;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no progress for %0d cycles", $realtime, idle_cycles);
            $display("psg_register_write_pitch_tracker_top regression: fail");
            $finish;
        end
    end

    initial begin
        logic [NUMER_W-1:0] numer;
        err_count   = 0;
        items_sent  = 0;
        burst_left  = 0;
        gap_max     = 8;
        burst_max   = 4;
        rdy_mode    = RDY_RANDOM;
        rdy_hold    = 0;
        idle_cycles = 0;
        reset_pitch_model();
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte(dir_rows[i].data, dir_rows[i].kind,
                      '{voice: dir_rows[i].voice, freq: dir_rows[i].freq});
        end
        stop_sending();

        for (int p = 1; p <= PHASES; p++) begin
            case (p)
                1: numer = '1;
                2: numer = NUMER_W'(1);
                4: numer = NUMER_W'(2);
                5: numer = NUMER_W'($urandom_range(1, 1023));
                6: numer = NUMER_RESET;
                default: numer = NUMER_W'($urandom_range(1, 131071));
            endcase
            write_numerator(numer);
            gap_max   = (p % 3 == 0) ? 0 : p * 5;
            burst_max = 1 + p * 2;
            rdy_mode  = t_rdy_mode'(p % 3);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) random_sequence();
            stop_sending();
        end

        drain();
        if (pitch_change_q.size() != 0) report("items left over", pitch_change_q.size(), 0);
        if (err_count == 0) begin
            $display("psg_register_write_pitch_tracker_top regression: pass");
        end else begin
            $display("psg_register_write_pitch_tracker_top regression: fail");
        end
        $finish;
    end

endmodule
